@@ design/marker_bounded_region_defines.svh @@
// ---------------------------------------------------------------------------
// Marker bounded region assertion macros
// Shared property forms for the region checker.
// ---------------------------------------------------------------------------
`ifndef MARKER_BOUNDED_REGION_DEFINES_SVH
`define MARKER_BOUNDED_REGION_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MBR_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("marker_bounded_region: check failed");

// next-cycle implication, sampled on clk, off during reset
`define MBR_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("marker_bounded_region: check failed");

`endif

@@ design/mbr_pkg.sv @@
// ---------------------------------------------------------------------------
// Marker bounded region package
// Shared constants, side codes and the tracker event type.
// ---------------------------------------------------------------------------
package mbr_pkg;

	localparam int CORNERS_PER_MARKER = 4;
	localparam int COORD_BITS_DEF     = 16;
	localparam int CNT_W              = $clog2(CORNERS_PER_MARKER);
	localparam int OUT_BITS           = 12;
	localparam int CENTER_FRAC        = 6;
	localparam int EDGE_SHIFT         = 2;
	localparam int NUM_SIDES          = 4;

	localparam logic [1:0] SIDE_LEFT   = 2'd0;
	localparam logic [1:0] SIDE_RIGHT  = 2'd1;
	localparam logic [1:0] SIDE_TOP    = 2'd2;
	localparam logic [1:0] SIDE_BOTTOM = 2'd3;

	typedef struct packed {
		logic done;
		logic err;
	} mbr_evt_t;

endpackage

@@ design/mbr_if.sv @@
// ---------------------------------------------------------------------------
// Marker bounded region channels
// Corner input channel and region result channel, valid/ready per beat.
// ---------------------------------------------------------------------------
interface mbr_corner_if import mbr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] point_x;
	logic [COORD_BITS-1:0] point_y;
	logic                  last_in_set;

	modport source (output valid, point_x, point_y, last_in_set, input ready);
	modport sink   (input valid, point_x, point_y, last_in_set, output ready);
endinterface

interface mbr_region_if import mbr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OUT_BITS-1:0] region_x_min;
	logic [OUT_BITS-1:0] region_y_min;
	logic [OUT_BITS-1:0] region_x_max;
	logic [OUT_BITS-1:0] region_y_max;
	logic                set_error;

	modport source (output valid, region_x_min, region_y_min, region_x_max, region_y_max,
		set_error, input ready);
	modport sink   (input valid, region_x_min, region_y_min, region_x_max, region_y_max,
		set_error, output ready);
endinterface

@@ design/mbr_tracker.sv @@
// ---------------------------------------------------------------------------
// Marker bounded region tracker
// Accumulates one marker's corners and keeps the four extreme markers.
// ---------------------------------------------------------------------------
module mbr_tracker import mbr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [COORD_BITS-1:0] point_x,
	input  logic [COORD_BITS-1:0] point_y,
	input  logic                  last_in_set,
	output mbr_evt_t              evt,
	output logic [COORD_BITS-1:0] side_edge  [NUM_SIDES],
	output logic [COORD_BITS+1:0] side_cross [NUM_SIDES]
);

	localparam int SUM_W = COORD_BITS + 2;

	logic [CNT_W-1:0]      cnt_q;
	logic                  have_q;
	logic [SUM_W-1:0]      sum_x_q, sum_y_q;
	logic [COORD_BITS-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic [SUM_W-1:0]      key_q   [NUM_SIDES];
	logic [COORD_BITS-1:0] edge_q  [NUM_SIDES];
	logic [SUM_W-1:0]      cross_q [NUM_SIDES];

	logic                  start, complete, first;
	logic [SUM_W-1:0]      sum_x_n, sum_y_n;
	logic [COORD_BITS-1:0] min_x_n, max_x_n, min_y_n, max_y_n;
	logic [SUM_W-1:0]      cand_key   [NUM_SIDES];
	logic [COORD_BITS-1:0] cand_edge  [NUM_SIDES];
	logic [SUM_W-1:0]      cand_cross [NUM_SIDES];
	logic [NUM_SIDES-1:0]  take;

	assign start    = (cnt_q == '0);
	assign complete = (cnt_q == CNT_W'(CORNERS_PER_MARKER - 1));
	assign first    = !have_q;

	always_comb begin
		if (start) begin
			sum_x_n = SUM_W'(point_x);
			sum_y_n = SUM_W'(point_y);
			min_x_n = point_x;
			max_x_n = point_x;
			min_y_n = point_y;
			max_y_n = point_y;
		end else begin
			sum_x_n = sum_x_q + SUM_W'(point_x);
			sum_y_n = sum_y_q + SUM_W'(point_y);
			min_x_n = (point_x < min_x_q) ? point_x : min_x_q;
			max_x_n = (point_x > max_x_q) ? point_x : max_x_q;
			min_y_n = (point_y < min_y_q) ? point_y : min_y_q;
			max_y_n = (point_y > max_y_q) ? point_y : max_y_q;
		end
	end

	always_comb begin
		cand_key[SIDE_LEFT]     = sum_x_n;
		cand_edge[SIDE_LEFT]    = max_x_n;
		cand_cross[SIDE_LEFT]   = sum_y_n;
		cand_key[SIDE_RIGHT]    = sum_x_n;
		cand_edge[SIDE_RIGHT]   = min_x_n;
		cand_cross[SIDE_RIGHT]  = sum_y_n;
		cand_key[SIDE_TOP]      = sum_y_n;
		cand_edge[SIDE_TOP]     = max_y_n;
		cand_cross[SIDE_TOP]    = sum_x_n;
		cand_key[SIDE_BOTTOM]   = sum_y_n;
		cand_edge[SIDE_BOTTOM]  = min_y_n;
		cand_cross[SIDE_BOTTOM] = sum_x_n;
		take[SIDE_LEFT]   = first || (sum_x_n < key_q[SIDE_LEFT]);
		take[SIDE_RIGHT]  = first || (sum_x_n > key_q[SIDE_RIGHT]);
		take[SIDE_TOP]    = first || (sum_y_n < key_q[SIDE_TOP]);
		take[SIDE_BOTTOM] = first || (sum_y_n > key_q[SIDE_BOTTOM]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			have_q <= 1'b0;
		end else if (fire) begin
			if (last_in_set) begin
				cnt_q  <= '0;
				have_q <= 1'b0;
			end else if (complete) begin
				cnt_q  <= '0;
				have_q <= 1'b1;
			end else begin
				cnt_q  <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			sum_x_q <= sum_x_n;
			sum_y_q <= sum_y_n;
			min_x_q <= min_x_n;
			max_x_q <= max_x_n;
			min_y_q <= min_y_n;
			max_y_q <= max_y_n;
			for (int s = 0; s < NUM_SIDES; s++) begin
				if (complete && take[s]) begin
					key_q[s]   <= cand_key[s];
					edge_q[s]  <= cand_edge[s];
					cross_q[s] <= cand_cross[s];
				end
			end
		end
	end

	assign evt.done = fire && last_in_set;
	assign evt.err  = !complete;

	always_comb begin
		for (int s = 0; s < NUM_SIDES; s++) begin
			side_edge[s]  = edge_q[s];
			side_cross[s] = cross_q[s];
		end
	end

endmodule

@@ design/marker_bounded_region.sv @@
// ---------------------------------------------------------------------------
// Marker bounded region
// Bounding box of the inner corners of the extreme markers in a corner set.
// ---------------------------------------------------------------------------
// Takes one corner beat per cycle unless stalled, four corners per marker,
// and answers each set (closed by last_in_set) with one region beat when
// the output is free. The marker sums and the extreme-marker registers are
// updated in the first stage, one corner per cycle unless stalled; the box
// is formed from them in the second stage and held in the output register,
// so new corners keep flowing while a region beat waits.
// A set that ends in the middle of a marker returns set_error with a zero box.
module marker_bounded_region import mbr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	mbr_corner_if.sink    corner,
	mbr_region_if.source  region
);

	localparam int SUM_W = COORD_BITS + 2;
	localparam int EXT_W = (SUM_W > OUT_BITS + CENTER_FRAC) ? SUM_W : OUT_BITS + CENTER_FRAC;

	logic                  valid_s1, last_s1;
	logic [COORD_BITS-1:0] x_s1, y_s1;
	logic                  valid_s2, err_s2;
	logic                  out_valid_q, err_q;
	logic [OUT_BITS-1:0]   x_min_q, y_min_q, x_max_q, y_max_q;

	logic                  adv_out, s2_free, s1_fire;
	mbr_evt_t              evt;
	logic [COORD_BITS-1:0] side_edge  [NUM_SIDES];
	logic [SUM_W-1:0]      side_cross [NUM_SIDES];

	logic [SUM_W-1:0]      xv [NUM_SIDES];
	logic [SUM_W-1:0]      yv [NUM_SIDES];
	logic [SUM_W-1:0]      x_lo, x_hi, y_lo, y_hi;
	logic [SUM_W-1:0]      xa_lo, xa_hi, xb_lo, xb_hi, ya_lo, ya_hi, yb_lo, yb_hi;
	logic [EXT_W-1:0]      x_lo_e, x_hi_e, y_lo_e, y_hi_e;

	assign adv_out      = !out_valid_q || region.ready;
	assign s2_free      = !valid_s2 || adv_out;
	assign s1_fire      = valid_s1 && s2_free;
	assign corner.ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (corner.ready)
				valid_s1 <= corner.valid;
			if (s2_free)
				valid_s2 <= evt.done;
			if (adv_out)
				out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (corner.valid && corner.ready) begin
			x_s1    <= corner.point_x;
			y_s1    <= corner.point_y;
			last_s1 <= corner.last_in_set;
		end
		if (s2_free)
			err_s2 <= evt.err;
		if (adv_out) begin
			err_q   <= err_s2;
			x_min_q <= err_s2 ? '0 : x_lo_e[OUT_BITS+CENTER_FRAC-1:CENTER_FRAC];
			y_min_q <= err_s2 ? '0 : y_lo_e[OUT_BITS+CENTER_FRAC-1:CENTER_FRAC];
			x_max_q <= err_s2 ? '0 : x_hi_e[OUT_BITS+CENTER_FRAC-1:CENTER_FRAC];
			y_max_q <= err_s2 ? '0 : y_hi_e[OUT_BITS+CENTER_FRAC-1:CENTER_FRAC];
		end
	end

	mbr_tracker #(
		.COORD_BITS (COORD_BITS)
	) u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (s1_fire),
		.point_x     (x_s1),
		.point_y     (y_s1),
		.last_in_set (last_s1),
		.evt         (evt),
		.side_edge   (side_edge),
		.side_cross  (side_cross)
	);

	// align edges to the scale of the corner sums, then take the extremes
	always_comb begin
		xv[SIDE_LEFT]   = SUM_W'(side_edge[SIDE_LEFT]) << EDGE_SHIFT;
		xv[SIDE_RIGHT]  = SUM_W'(side_edge[SIDE_RIGHT]) << EDGE_SHIFT;
		xv[SIDE_TOP]    = side_cross[SIDE_TOP];
		xv[SIDE_BOTTOM] = side_cross[SIDE_BOTTOM];
		yv[SIDE_LEFT]   = side_cross[SIDE_LEFT];
		yv[SIDE_RIGHT]  = side_cross[SIDE_RIGHT];
		yv[SIDE_TOP]    = SUM_W'(side_edge[SIDE_TOP]) << EDGE_SHIFT;
		yv[SIDE_BOTTOM] = SUM_W'(side_edge[SIDE_BOTTOM]) << EDGE_SHIFT;

		xa_lo = (xv[SIDE_LEFT] < xv[SIDE_RIGHT]) ? xv[SIDE_LEFT] : xv[SIDE_RIGHT];
		xa_hi = (xv[SIDE_LEFT] > xv[SIDE_RIGHT]) ? xv[SIDE_LEFT] : xv[SIDE_RIGHT];
		xb_lo = (xv[SIDE_TOP] < xv[SIDE_BOTTOM]) ? xv[SIDE_TOP] : xv[SIDE_BOTTOM];
		xb_hi = (xv[SIDE_TOP] > xv[SIDE_BOTTOM]) ? xv[SIDE_TOP] : xv[SIDE_BOTTOM];
		ya_lo = (yv[SIDE_LEFT] < yv[SIDE_RIGHT]) ? yv[SIDE_LEFT] : yv[SIDE_RIGHT];
		ya_hi = (yv[SIDE_LEFT] > yv[SIDE_RIGHT]) ? yv[SIDE_LEFT] : yv[SIDE_RIGHT];
		yb_lo = (yv[SIDE_TOP] < yv[SIDE_BOTTOM]) ? yv[SIDE_TOP] : yv[SIDE_BOTTOM];
		yb_hi = (yv[SIDE_TOP] > yv[SIDE_BOTTOM]) ? yv[SIDE_TOP] : yv[SIDE_BOTTOM];

		x_lo = (xa_lo < xb_lo) ? xa_lo : xb_lo;
		x_hi = (xa_hi > xb_hi) ? xa_hi : xb_hi;
		y_lo = (ya_lo < yb_lo) ? ya_lo : yb_lo;
		y_hi = (ya_hi > yb_hi) ? ya_hi : yb_hi;

		x_lo_e = EXT_W'(x_lo);
		x_hi_e = EXT_W'(x_hi);
		y_lo_e = EXT_W'(y_lo);
		y_hi_e = EXT_W'(y_hi);
	end

	assign region.valid        = out_valid_q;
	assign region.region_x_min = x_min_q;
	assign region.region_y_min = y_min_q;
	assign region.region_x_max = x_max_q;
	assign region.region_y_max = y_max_q;
	assign region.set_error    = err_q;

endmodule

@@ design/mbr_checker.sv @@
// ---------------------------------------------------------------------------
// Marker bounded region checker
// Port-level checks on result beats against accepted set ends.
// ---------------------------------------------------------------------------
`include "marker_bounded_region_defines.svh"

module mbr_checker import mbr_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                corner_valid,
	input logic                corner_ready,
	input logic                corner_last,
	input logic                region_valid,
	input logic                region_ready,
	input logic [OUT_BITS-1:0] region_x_min,
	input logic [OUT_BITS-1:0] region_y_min,
	input logic [OUT_BITS-1:0] region_x_max,
	input logic [OUT_BITS-1:0] region_y_max,
	input logic                set_error
);

	logic [2:0] pend_q;
	logic       set_end, beat_out;

	assign set_end  = corner_valid && corner_ready && corner_last;
	assign beat_out = region_valid && region_ready;

	// count set ends taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else
			pend_q <= pend_q + {2'b00, set_end} - {2'b00, beat_out};
	end

	`MBR_ASSERT_NEXT(a_hold, region_valid && !region_ready, region_valid && $stable(region_x_min) && $stable(region_y_min) && $stable(region_x_max) && $stable(region_y_max) && $stable(set_error))
	`MBR_ASSERT_NOW(a_err_zero, region_valid && set_error, region_x_min == '0 && region_y_min == '0 && region_x_max == '0 && region_y_max == '0)
	`MBR_ASSERT_NOW(a_no_orphan, region_valid, pend_q != 3'd0)
	`MBR_ASSERT_NOW(a_depth, corner_valid || region_valid, pend_q <= 3'd3)

endmodule

bind marker_bounded_region mbr_checker u_mbr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.corner_valid (corner.valid),
	.corner_ready (corner.ready),
	.corner_last  (corner.last_in_set),
	.region_valid (region.valid),
	.region_ready (region.ready),
	.region_x_min (region.region_x_min),
	.region_y_min (region.region_y_min),
	.region_x_max (region.region_x_max),
	.region_y_max (region.region_y_max),
	.set_error    (region.set_error)
);
